// ===== sv/rdm_queued_message_stack_assert.svh =====
// ---------------------------------------------------------------------------
// rdm_queued_message_stack_assert.svh
// assertion macros shared by the queued message stack
// ---------------------------------------------------------------------------
`ifndef RDM_QUEUED_MESSAGE_STACK_ASSERT_SVH
`define RDM_QUEUED_MESSAGE_STACK_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rdm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdm_pkg
// types and codes of the queued message stack
// ---------------------------------------------------------------------------
package rdm_pkg;

    typedef enum logic [1:0] {
        REQ_STAGE  = 2'd0,
        REQ_COMMIT = 2'd1,
        REQ_GET    = 2'd2,
        REQ_NONE   = 2'd3
    } req_code_t;

    localparam logic [7:0]  STATUS_GET_LAST     = 8'd1;
    localparam logic [15:0] STATUS_MESSAGES_PID = 16'h0030;

    // slot header as stored in the header memory
    typedef struct packed {
        logic [7:0]  len;
        logic [15:0] pid;
        logic [7:0]  cls;
    } hdr_t;

endpackage

// ===== sv/rdm_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdm_req_if
// request channel: stage byte, commit header, get message
// ---------------------------------------------------------------------------
interface rdm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic [7:0]  msg_class;
    logic [15:0] msg_pid;
    logic [7:0]  param_length;
    logic [7:0]  status_type;

    modport source (
        output valid, req_type, data_byte, msg_class, msg_pid, param_length,
               status_type,
        input  ready
    );
    modport sink (
        input  valid, req_type, data_byte, msg_class, msg_pid, param_length,
               status_type,
        output ready
    );
endinterface

// ===== sv/rdm_rsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdm_rsp_if
// result channel: status and reply words
// ---------------------------------------------------------------------------
interface rdm_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        empty_reply;
    logic [7:0]  reply_class;
    logic [15:0] reply_pid;
    logic [7:0]  reply_length;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic [4:0]  message_count;
    logic        last;

    modport source (
        output valid, accepted, empty_reply, reply_class, reply_pid, reply_length,
               data_word, byte_count, message_count, last,
        input  ready
    );
    modport sink (
        input  valid, accepted, empty_reply, reply_class, reply_pid, reply_length,
               data_word, byte_count, message_count, last,
        output ready
    );
endinterface

// ===== sv/rdm_hdr_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdm_hdr_mem
// slot header memory, one write and one registered read port, with a
// valid bit per slot so that reset reads as a cleared header
// ---------------------------------------------------------------------------
module rdm_hdr_mem #(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_W     = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [SLOT_W-1:0]  wr_addr,
    input  rdm_pkg::hdr_t      wr_data,
    input  logic               rd_en,
    input  logic [SLOT_W-1:0]  rd_addr,
    output rdm_pkg::hdr_t      rd_data
);

    rdm_pkg::hdr_t           mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   vld_reg;
    rdm_pkg::hdr_t           rd_data_reg;
    logic                    rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // never written slot reads as all zeros
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== sv/rdm_data_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdm_data_mem
// message data memory, 32-bit words with a single byte-lane write port
// and a registered word read port
// ---------------------------------------------------------------------------
module rdm_data_mem #(
    parameter int DEPTH = 928,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_lane,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [3:0][7:0] mem [DEPTH];
    logic [31:0]     rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr][wr_lane] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/rdm_queued_message_stack.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdm_queued_message_stack
// stack of queued message slots: stages data bytes, commits headers and
// streams a popped or last message as four-byte words
// ---------------------------------------------------------------------------
//  channel  dir  payload                                         done when
//  req      in   req_type data_byte msg_class msg_pid            valid & ready
//                param_length status_type
//  rsp      out  accepted empty_reply reply_class reply_pid      valid & ready
//                reply_length data_word byte_count message_count last
//
//  stage, commit and unknown items each give one item
//  a get reads the header and first data word, then gives one word per cycle
//  while rsp is ready; words come from the single word read port
//  reset clears header valid bits at once; no clearing pass
//  a stalled rsp holds the current word; req is taken only between items
// ---------------------------------------------------------------------------
`include "rdm_queued_message_stack_assert.svh"

module rdm_queued_message_stack #(
    parameter int SLOT_COUNT     = 16,
    parameter int MAX_DATA_BYTES = 231
) (
    input  logic       clk,
    input  logic       rst_n,
    rdm_req_if.sink    req,
    rdm_rsp_if.source  rsp
);

    localparam int WPS    = (MAX_DATA_BYTES + 3) / 4;
    localparam int DEPTH  = SLOT_COUNT * WPS;
    localparam int DA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int NR_W   = $clog2(WPS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_SEND
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    qc_reg, qc_next;
    logic                nq_reg, nq_next;
    logic [7:0]          si_reg, si_next;
    logic [7:0]          rem_reg, rem_next;
    logic [NR_W-1:0]     nrd_reg, nrd_next;
    logic [DA_W-1:0]     base_reg, base_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_acc_reg, out_acc_next;
    logic                out_empty_reg, out_empty_next;
    logic [7:0]          out_cls_reg, out_cls_next;
    logic [15:0]         out_pid_reg, out_pid_next;
    logic [7:0]          out_len_reg, out_len_next;
    logic [31:0]         out_word_reg, out_word_next;
    logic [2:0]          out_cnt_reg, out_cnt_next;
    logic [4:0]          out_mcnt_reg, out_mcnt_next;
    logic                out_last_reg, out_last_next;

    logic                req_acc;
    logic                out_free;
    logic [SLOT_W-1:0]   qc_slot;
    logic [SLOT_W-1:0]   get_slot;
    logic [7:0]          plen_clamp;

    logic                hwr_en, hrd_en;
    rdm_pkg::hdr_t       hwr_data, hrd_data;
    logic                dwr_en, drd_en;
    logic [DA_W-1:0]     dwr_addr, drd_addr;
    logic [31:0]         drd_data;

    // word loader, shared by the header cycle and the streaming cycles
    logic [7:0]          ld_rem;
    logic [2:0]          ld_cnt;
    logic                ld_last;
    logic [31:0]         ld_word;

    rdm_hdr_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_hdr_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (hwr_en),
        .wr_addr (qc_slot),
        .wr_data (hwr_data),
        .rd_en   (hrd_en),
        .rd_addr (get_slot),
        .rd_data (hrd_data)
    );

    rdm_data_mem #(
        .DEPTH (DEPTH),
        .AW    (DA_W)
    ) u_data_mem (
        .clk     (clk),
        .wr_en   (dwr_en),
        .wr_addr (dwr_addr),
        .wr_lane (si_reg[1:0]),
        .wr_data (req.data_byte),
        .rd_en   (drd_en),
        .rd_addr (drd_addr),
        .rd_data (drd_data)
    );

    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign req_acc = req.valid && req.ready;

    assign qc_slot    = SLOT_W'(qc_reg);
    assign get_slot   = (req.status_type == rdm_pkg::STATUS_GET_LAST) ?
                        SLOT_W'(qc_reg) : SLOT_W'(qc_reg - CNT_W'(1));
    assign plen_clamp = (req.param_length > 8'(MAX_DATA_BYTES)) ?
                        8'(MAX_DATA_BYTES) : req.param_length;
    assign hwr_data   = '{len: plen_clamp, pid: req.msg_pid, cls: req.msg_class};
    assign dwr_addr   = DA_W'(qc_slot * WPS) + DA_W'(si_reg[7:2]);

    assign ld_rem  = (state_reg == ST_HDR) ? hrd_data.len : rem_reg;
    assign ld_cnt  = (ld_rem >= 8'd4) ? 3'd4 : ld_rem[2:0];
    assign ld_last = (ld_rem <= 8'd4);

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            ld_word[8*b +: 8] = (3'(b) < ld_cnt) ? drd_data[8*b +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        qc_next        = qc_reg;
        nq_next        = nq_reg;
        si_next        = si_reg;
        rem_next       = rem_reg;
        nrd_next       = nrd_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg;
        out_acc_next   = out_acc_reg;
        out_empty_next = out_empty_reg;
        out_cls_next   = out_cls_reg;
        out_pid_next   = out_pid_reg;
        out_len_next   = out_len_reg;
        out_word_next  = out_word_reg;
        out_cnt_next   = out_cnt_reg;
        out_mcnt_next  = out_mcnt_reg;
        out_last_next  = out_last_reg;
        hwr_en         = 1'b0;
        hrd_en         = 1'b0;
        dwr_en         = 1'b0;
        drd_en         = 1'b0;
        drd_addr       = base_reg + DA_W'(nrd_reg);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    // single-item result by default
                    out_valid_next = 1'b1;
                    out_acc_next   = 1'b0;
                    out_empty_next = 1'b0;
                    out_cls_next   = 8'd0;
                    out_pid_next   = 16'd0;
                    out_len_next   = 8'd0;
                    out_word_next  = 32'd0;
                    out_cnt_next   = 3'd0;
                    out_last_next  = 1'b1;
                    unique case (rdm_pkg::req_code_t'(req.req_type))
                        rdm_pkg::REQ_STAGE:
                        begin
                            if (qc_reg < CNT_W'(SLOT_COUNT) &&
                                si_reg < 8'(MAX_DATA_BYTES))
                            begin
                                dwr_en       = 1'b1;
                                si_next      = si_reg + 8'd1;
                                out_acc_next = 1'b1;
                            end
                        end
                        rdm_pkg::REQ_COMMIT:
                        begin
                            nq_next = 1'b0;
                            si_next = 8'd0;
                            if (qc_reg < CNT_W'(SLOT_COUNT))
                            begin
                                hwr_en       = 1'b1;
                                qc_next      = qc_reg + CNT_W'(1);
                                out_acc_next = 1'b1;
                            end
                        end
                        rdm_pkg::REQ_GET:
                        begin
                            if (nq_reg ||
                                (req.status_type == rdm_pkg::STATUS_GET_LAST &&
                                 qc_reg >= CNT_W'(SLOT_COUNT)) ||
                                (req.status_type != rdm_pkg::STATUS_GET_LAST &&
                                 qc_reg == '0))
                            begin
                                out_empty_next = 1'b1;
                                out_pid_next   = rdm_pkg::STATUS_MESSAGES_PID;
                            end
                            else
                            begin
                                // read header and first word, stream from there
                                out_valid_next = 1'b0;
                                hrd_en         = 1'b1;
                                drd_en         = 1'b1;
                                base_next      = DA_W'(get_slot * WPS);
                                drd_addr       = DA_W'(get_slot * WPS);
                                nrd_next       = NR_W'(1);
                                state_next     = ST_HDR;
                                if (req.status_type != rdm_pkg::STATUS_GET_LAST)
                                begin
                                    qc_next = qc_reg - CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    out_mcnt_next = 5'(qc_next);
                end
            end
            ST_HDR:
            begin
                out_valid_next = 1'b1;
                out_acc_next   = 1'b0;
                out_empty_next = 1'b0;
                out_cls_next   = hrd_data.cls;
                out_pid_next   = hrd_data.pid;
                out_len_next   = hrd_data.len;
                out_word_next  = ld_word;
                out_cnt_next   = ld_cnt;
                out_last_next  = ld_last;
                out_mcnt_next  = 5'(qc_reg);
                rem_next       = ld_rem - 8'd4;
                if (nrd_reg < NR_W'(WPS))
                begin
                    drd_en   = 1'b1;
                    nrd_next = nrd_reg + NR_W'(1);
                end
                state_next = ld_last ? ST_IDLE : ST_SEND;
            end
            ST_SEND:
            begin
                if (rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = ld_word;
                    out_cnt_next   = ld_cnt;
                    out_last_next  = ld_last;
                    rem_next       = ld_rem - 8'd4;
                    if (nrd_reg < NR_W'(WPS))
                    begin
                        drd_en   = 1'b1;
                        nrd_next = nrd_reg + NR_W'(1);
                    end
                    if (ld_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            qc_reg        <= '0;
            nq_reg        <= 1'b1;
            si_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            qc_reg        <= qc_next;
            nq_reg        <= nq_next;
            si_reg        <= si_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        nrd_reg       <= nrd_next;
        base_reg      <= base_next;
        out_acc_reg   <= out_acc_next;
        out_empty_reg <= out_empty_next;
        out_cls_reg   <= out_cls_next;
        out_pid_reg   <= out_pid_next;
        out_len_reg   <= out_len_next;
        out_word_reg  <= out_word_next;
        out_cnt_reg   <= out_cnt_next;
        out_mcnt_reg  <= out_mcnt_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.accepted      = out_acc_reg;
    assign rsp.empty_reply   = out_empty_reg;
    assign rsp.reply_class   = out_cls_reg;
    assign rsp.reply_pid     = out_pid_reg;
    assign rsp.reply_length  = out_len_reg;
    assign rsp.data_word     = out_word_reg;
    assign rsp.byte_count    = out_cnt_reg;
    assign rsp.message_count = out_mcnt_reg;
    assign rsp.last          = out_last_reg;

    `RDM_ASSERT_NOW(a_busy_blocks_req, state_reg != ST_IDLE, !req.ready, "req taken mid reply")
    `RDM_ASSERT_NEXT(a_stream_no_gap, rsp.valid && rsp.ready && !rsp.last && state_reg == ST_SEND, rsp.valid, "gap in reply words")
    `RDM_ASSERT_NEXT(a_commit_rewinds, req.valid && req.ready && req.req_type == rdm_pkg::REQ_COMMIT, si_reg == 8'd0, "stage index kept after commit")
    `RDM_ASSERT_NOW(a_count_range, 1'b1, qc_reg <= CNT_W'(SLOT_COUNT), "message count past capacity")

endmodule
